// File: rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared constants and the arctangent table for the quaternion to Euler core.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int FRAC_BITS_DEF     = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    // Widths of the exact Q28 arithmetic
    localparam int PROD_W = 32;     // 16x16 signed product
    localparam int SUM_W  = 34;     // 2*(a*b + c*d) and 1 - 2*(...)
    localparam int SIN_W  = 30;     // clamped pitch sine
    localparam int MAG_W  = 29;     // |sine|, up to 2^28
    localparam int RAD_W  = 58;     // radicand 2^56 - s^2, padded to even width
    localparam int ROOT_W = 29;     // floor square root of the radicand
    localparam int REM_W  = 32;     // square root remainder
    localparam int SQ_STEPS = RAD_W / 2;

    // Angle accumulator in 1/65536 degree
    localparam int ZW = 26;
    localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int ROLL_LIM  = 23040;
    localparam int PITCH_LIM = 11520;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ZW-1:0] atan_lut(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(2949120);
            1:  v = ZW'(1740967);
            2:  v = ZW'(919879);
            3:  v = ZW'(466945);
            4:  v = ZW'(234379);
            5:  v = ZW'(117304);
            6:  v = ZW'(58666);
            7:  v = ZW'(29335);
            8:  v = ZW'(14668);
            9:  v = ZW'(7334);
            10: v = ZW'(3667);
            11: v = ZW'(1833);
            12: v = ZW'(917);
            13: v = ZW'(458);
            14: v = ZW'(229);
            15: v = ZW'(115);
            16: v = ZW'(57);
            17: v = ZW'(29);
            18: v = ZW'(14);
            19: v = ZW'(7);
            20: v = ZW'(4);
            21: v = ZW'(2);
            22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/quaternion_to_euler_degrees_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_core
// Quaternion (Q2.14) to roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one quaternion per transaction;
//   output channel o_valid / i_stall carries roll, pitch and yaw.
//   A transaction completes on a rising edge with valid high and stall low.
//   Throughput is one quaternion per cycle while no stall holds the flow.
//   A quaternion passes through the front end (products, sums, a 29-stage
//   square root for the pitch cosine and rescaling), the queue, then a
//   folding stage, the CORDIC stages and a rounding stage.
//   When the receiver stalls, the back end holds; the front end keeps going
//   until the four-entry queue fills, and only then is o_stall raised.
//   Synchronous reset empties all pipelines and the queue; no result is
//   pending afterwards. The block keeps no state between quaternions.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_core import q2e_pkg::*; #(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [15:0]        i_quat_x,
    input  logic signed [15:0]        i_quat_y,
    input  logic signed [15:0]        i_quat_z,
    input  logic signed [15:0]        i_quat_w,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [ROLL_W-1:0]  o_roll_angle,
    output logic signed [PITCH_W-1:0] o_pitch_angle,
    output logic signed [ROLL_W-1:0]  o_yaw_angle
);

    localparam int CW = FRAC_BITS + 9;
    localparam int EW = 6 * CW + 3;
    localparam int BL = CORDIC_STAGES + 2;

    logic          push, pop, q_full, q_empty, be;
    logic [EW-1:0] f_data, q_data;
    logic [BL-1:0] r_bv;

    // front end
    q2e_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_quat_w (i_quat_w),
        .i_q_full (q_full),
        .o_stall  (o_stall),
        .o_push   (push),
        .o_data   (f_data)
    );

    // decoupling queue
    q2e_fifo #(.W(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    // back end advances unless a finished result is held by the receiver
    assign be  = !(r_bv[BL-1] && i_stall);
    assign pop = be && !q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (be) begin
            r_bv <= {r_bv[BL-2:0], pop};
        end
    end

    assign o_valid = r_bv[BL-1];

    // three CORDIC lanes
    q2e_cordic #(.CW(CW), .STAGES(CORDIC_STAGES), .OUT_W(ROLL_W), .LIM(ROLL_LIM)) u_roll (
        .i_clk   (i_clk),
        .i_en    (be),
        .i_x     (q_data[4*CW +: CW]),
        .i_y     (q_data[5*CW +: CW]),
        .i_zero  (q_data[6*CW+2]),
        .o_angle (o_roll_angle)
    );

    q2e_cordic #(.CW(CW), .STAGES(CORDIC_STAGES), .OUT_W(PITCH_W), .LIM(PITCH_LIM)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (be),
        .i_x     (q_data[2*CW +: CW]),
        .i_y     (q_data[3*CW +: CW]),
        .i_zero  (q_data[6*CW+1]),
        .o_angle (o_pitch_angle)
    );

    q2e_cordic #(.CW(CW), .STAGES(CORDIC_STAGES), .OUT_W(ROLL_W), .LIM(ROLL_LIM)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (be),
        .i_x     (q_data[0 +: CW]),
        .i_y     (q_data[CW +: CW]),
        .i_zero  (q_data[6*CW]),
        .o_angle (o_yaw_angle)
    );

endmodule

// File: rtl/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Front end: exact Q28 products and sums, pitch cosine by a pipelined square
// root, and rescaling of the three arctangent operand pairs.
// ----------------------------------------------------------------------------
module q2e_front import q2e_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CW = FRAC_BITS + 9,
    localparam int EW = 6 * CW + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    input  logic signed [15:0]   i_quat_w,
    input  logic                 i_q_full,
    output logic                 o_stall,
    output logic                 o_push,
    output logic [EW-1:0]        o_data
);

    localparam int UP = (FRAC_BITS > 28) ? FRAC_BITS - 28 : 0;
    localparam int DN = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) <<< 28;

    // Q28 to Q(FRAC_BITS), floor on the way down
    function automatic logic signed [CW-1:0] resc(input logic signed [SUM_W-1:0] v);
        logic signed [CW+SUM_W-1:0] w;
        w = (CW + SUM_W)'(v);
        w = w <<< UP;
        w = w >>> DN;
        return w[CW-1:0];
    endfunction

    logic fe;
    logic r5_v;

    // whole front advances unless its last stage is blocked by a full queue
    assign fe      = !(r5_v && i_q_full);
    assign o_stall = !fe;
    assign o_push  = r5_v && !i_q_full;

    // stage 1: products
    logic r1_v;
    logic signed [PROD_W-1:0] r1_wx, r1_yz, r1_wz, r1_xy, r1_wy, r1_zx, r1_xx, r1_yy, r1_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (fe) begin
            r1_v <= i_valid;
        end
        if (fe) begin
            r1_wx <= i_quat_w * i_quat_x;
            r1_yz <= i_quat_y * i_quat_z;
            r1_wz <= i_quat_w * i_quat_z;
            r1_xy <= i_quat_x * i_quat_y;
            r1_wy <= i_quat_w * i_quat_y;
            r1_zx <= i_quat_z * i_quat_x;
            r1_xx <= i_quat_x * i_quat_x;
            r1_yy <= i_quat_y * i_quat_y;
            r1_zz <= i_quat_z * i_quat_z;
        end
    end

    // stage 2: sums, pitch sine clamp
    logic r2_v;
    logic signed [SUM_W-1:0] r2_rn, r2_rd, r2_yn, r2_yd;
    logic signed [SIN_W-1:0] r2_s;
    logic [MAG_W-1:0]        r2_sa;
    logic signed [SUM_W-1:0] n2_sraw;
    logic signed [SIN_W-1:0] n2_s;

    always_comb begin
        n2_sraw = (SUM_W'(r1_wy) - SUM_W'(r1_zx)) <<< 1;
        if (n2_sraw > ONE) begin
            n2_s = SIN_W'(ONE);
        end else if (n2_sraw < -ONE) begin
            n2_s = -SIN_W'(ONE);
        end else begin
            n2_s = n2_sraw[SIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (fe) begin
            r2_v <= r1_v;
        end
        if (fe) begin
            r2_rn <= (SUM_W'(r1_wx) + SUM_W'(r1_yz)) <<< 1;
            r2_rd <= ONE - ((SUM_W'(r1_xx) + SUM_W'(r1_yy)) <<< 1);
            r2_yn <= (SUM_W'(r1_wz) + SUM_W'(r1_xy)) <<< 1;
            r2_yd <= ONE - ((SUM_W'(r1_yy) + SUM_W'(r1_zz)) <<< 1);
            r2_s  <= n2_s;
            r2_sa <= n2_s[SIN_W-1] ? MAG_W'(-n2_s) : MAG_W'(n2_s);
        end
    end

    // stage 3: sine squared
    logic r3_v;
    logic signed [SUM_W-1:0] r3_rn, r3_rd, r3_yn, r3_yd;
    logic signed [SIN_W-1:0] r3_s;
    logic [RAD_W-1:0]        r3_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (fe) begin
            r3_v <= r2_v;
        end
        if (fe) begin
            r3_rn <= r2_rn;
            r3_rd <= r2_rd;
            r3_yn <= r2_yn;
            r3_yd <= r2_yd;
            r3_s  <= r2_s;
            r3_sq <= RAD_W'(r2_sa) * RAD_W'(r2_sa);
        end
    end

    // stage 4: radicand 1 - s^2
    logic r4_v;
    logic signed [SUM_W-1:0] r4_rn, r4_rd, r4_yn, r4_yd;
    logic signed [SIN_W-1:0] r4_s;
    logic [RAD_W-1:0]        r4_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (fe) begin
            r4_v <= r3_v;
        end
        if (fe) begin
            r4_rn <= r3_rn;
            r4_rd <= r3_rd;
            r4_yn <= r3_yn;
            r4_yd <= r3_yd;
            r4_s  <= r3_s;
            r4_n  <= (RAD_W'(1) << 56) - r3_sq;
        end
    end

    // square root: one result bit per stage
    logic                    r_qv  [SQ_STEPS];
    logic [REM_W-1:0]        r_rem [SQ_STEPS];
    logic [ROOT_W-1:0]       r_root[SQ_STEPS];
    logic [RAD_W-1:0]        r_nn  [SQ_STEPS];
    logic signed [SUM_W-1:0] r_qrn [SQ_STEPS];
    logic signed [SUM_W-1:0] r_qrd [SQ_STEPS];
    logic signed [SUM_W-1:0] r_qyn [SQ_STEPS];
    logic signed [SUM_W-1:0] r_qyd [SQ_STEPS];
    logic signed [SIN_W-1:0] r_qs  [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic                    p_v;
        logic [REM_W-1:0]        p_rem;
        logic [ROOT_W-1:0]       p_root;
        logic [RAD_W-1:0]        p_nn;
        logic signed [SUM_W-1:0] p_rn, p_rd, p_yn, p_yd;
        logic signed [SIN_W-1:0] p_s;
        logic [REM_W-1:0]        cur, trial;

        if (k == 0) begin : g_first
            assign p_v    = r4_v;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_nn   = r4_n;
            assign p_rn   = r4_rn;
            assign p_rd   = r4_rd;
            assign p_yn   = r4_yn;
            assign p_yd   = r4_yd;
            assign p_s    = r4_s;
        end else begin : g_next
            assign p_v    = r_qv[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_nn   = r_nn[k-1];
            assign p_rn   = r_qrn[k-1];
            assign p_rd   = r_qrd[k-1];
            assign p_yn   = r_qyn[k-1];
            assign p_yd   = r_qyd[k-1];
            assign p_s    = r_qs[k-1];
        end

        assign cur   = {p_rem[REM_W-3:0], p_nn[RAD_W-1 -: 2]};
        assign trial = {1'b0, p_root[ROOT_W-2:0], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qv[k] <= 1'b0;
            end else if (fe) begin
                r_qv[k] <= p_v;
            end
            if (fe) begin
                if (cur >= trial) begin
                    r_rem[k]  <= cur - trial;
                    r_root[k] <= {p_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= cur;
                    r_root[k] <= {p_root[ROOT_W-2:0], 1'b0};
                end
                r_nn[k]  <= p_nn << 2;
                r_qrn[k] <= p_rn;
                r_qrd[k] <= p_rd;
                r_qyn[k] <= p_yn;
                r_qyd[k] <= p_yd;
                r_qs[k]  <= p_s;
            end
        end
    end

    // stage 5: rescale operands, flag zero vectors
    logic signed [CW-1:0] n5_rx, n5_ry, n5_px, n5_py, n5_wx, n5_wy;
    logic [EW-1:0]        r5_d;

    always_comb begin
        n5_ry = resc(r_qrn[SQ_STEPS-1]);
        n5_rx = resc(r_qrd[SQ_STEPS-1]);
        n5_py = resc(SUM_W'(r_qs[SQ_STEPS-1]));
        n5_px = resc(SUM_W'({1'b0, r_root[SQ_STEPS-1]}));
        n5_wy = resc(r_qyn[SQ_STEPS-1]);
        n5_wx = resc(r_qyd[SQ_STEPS-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (fe) begin
            r5_v <= r_qv[SQ_STEPS-1];
        end
        if (fe) begin
            r5_d <= {(n5_rx == '0) && (n5_ry == '0),
                     (n5_px == '0) && (n5_py == '0),
                     (n5_wx == '0) && (n5_wy == '0),
                     n5_ry, n5_rx, n5_py, n5_px, n5_wy, n5_wx};
        end
    end

    assign o_data = r5_d;

endmodule

// File: rtl/q2e_fifo.sv
// ----------------------------------------------------------------------------
// q2e_fifo
// Four-entry queue between the front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module q2e_fifo import q2e_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined CORDIC vectoring atan2 with rounding to 1/128 degree and clamp.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; #(
    parameter int CW     = 23,
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int OUT_W  = ROLL_W,
    parameter int LIM    = ROLL_LIM
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [CW-1:0]    i_x,
    input  logic signed [CW-1:0]    i_y,
    input  logic                    i_zero,
    output logic signed [OUT_W-1:0] o_angle
);

    localparam logic signed [ZW-1:0] LIMV = ZW'(LIM);

    logic signed [CW-1:0] r_x [STAGES+1];
    logic signed [CW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic                 r_zf[STAGES+1];

    // quadrant fold for negative x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf[0] <= i_zero;
            if (!i_x[CW-1]) begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end else if (!i_y[CW-1]) begin
                r_x[0] <= i_y;
                r_y[0] <= -i_x;
                r_z[0] <= DEG90;
            end else begin
                r_x[0] <= -i_y;
                r_y[0] <= i_x;
                r_z[0] <= -DEG90;
            end
        end
    end

    // micro-rotations
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[i+1] <= r_zf[i];
                if (!r_y[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + atan_lut(i);
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - atan_lut(i);
                end
            end
        end
    end

    // round half up to 1/128 degree, clamp to range, zero for a zero vector
    logic signed [ZW-1:0]    rnd;
    logic signed [OUT_W-1:0] r_ang;

    assign rnd = (r_z[STAGES] + ZW'(256)) >>> 9;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_zf[STAGES]) begin
                r_ang <= '0;
            end else if (rnd > LIMV) begin
                r_ang <= OUT_W'(LIMV);
            end else if (rnd < -LIMV) begin
                r_ang <= OUT_W'(-LIMV);
            end else begin
                r_ang <= rnd[OUT_W-1:0];
            end
        end
    end

    assign o_angle = r_ang;

endmodule

// File: rtl/q2e_checker.sv
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks for the quaternion to Euler core, bound to the top level.
// ----------------------------------------------------------------------------
module q2e_checker import q2e_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic signed [15:0]        i_quat_x,
    input logic signed [15:0]        i_quat_y,
    input logic signed [15:0]        i_quat_z,
    input logic signed [15:0]        i_quat_w,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic signed [ROLL_W-1:0]  o_roll_angle,
    input logic signed [PITCH_W-1:0] o_pitch_angle,
    input logic signed [ROLL_W-1:0]  o_yaw_angle
);

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_roll_angle)
            && $stable(o_pitch_angle) && $stable(o_yaw_angle))
        else $error("held result changed");

    // a stalled input transaction stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_quat_x) && $stable(i_quat_y)
            && $stable(i_quat_z) && $stable(i_quat_w))
        else $error("stalled input changed");

    // nothing pending after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // pitch within +-90 degrees
    a_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch_angle >= -PITCH_LIM && o_pitch_angle <= PITCH_LIM)
        else $error("pitch out of range");

    // roll and yaw within +-180 degrees
    a_ry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_roll_angle >= -ROLL_LIM && o_roll_angle <= ROLL_LIM
            && o_yaw_angle >= -ROLL_LIM && o_yaw_angle <= ROLL_LIM)
        else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_degrees_core q2e_checker u_q2e_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the quaternion to Euler angle core against a bit-exact predictor of
// its fixed-point CORDIC arithmetic, with random gaps, receiver stalls and
// one long hold-off that fills the internal queue.
// ----------------------------------------------------------------------------
module tb;
    import q2e_pkg::*;

    localparam int LATENCY   = 37 + CORDIC_STAGES_DEF;
    localparam int MAX_CYC   = 400000;
    localparam int FRAC      = FRAC_BITS_DEF;
    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int HOLD_LEN  = 300;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  yaw;
    } t_angles;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic signed [15:0]        qx = '0, qy = '0, qz = '0, qw = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [ROLL_W-1:0]  roll, yaw;
    logic signed [PITCH_W-1:0] pitch;

    t_angles angles_due[$];
    int      errors = 0;
    int      cycles = 0;
    int      hold_cycles = 0;
    int      rx_wait = 0;
    bit      hold_req = 1'b0;
    bit      hold_seen = 1'b0;

    always #5 clk = ~clk;

    quaternion_to_euler_degrees_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_quat_x(qx), .i_quat_y(qy), .i_quat_z(qz), .i_quat_w(qw),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_roll_angle(roll), .o_pitch_angle(pitch), .o_yaw_angle(yaw)
    );

    // Floor shift of a signed value
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint to_frac(longint v);
        if (FRAC > 28) return v * (longint'(1) << (FRAC - 28));
        return shr_floor(v, 28 - FRAC);
    endfunction

    function automatic longint atan_units(int i);
        longint tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1};
        return (i < 23) ? tab[i] : 0;
    endfunction

    // Vectoring CORDIC on Q28 operands, angle in 1/65536 degree
    function automatic longint vector_angle(longint yq, longint xq);
        longint vx, vy, ang, t, sx, sy;
        vx = to_frac(xq);
        vy = to_frac(yq);
        ang = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            if (vy >= 0) begin
                t = vx; vx = vy; vy = -t; ang = 90 * 65536;
            end else begin
                t = vx; vx = -vy; vy = t; ang = -90 * 65536;
            end
        end
        for (int i = 0; i < STAGES && i < 32; i++) begin
            sx = shr_floor(vx, i);
            sy = shr_floor(vy, i);
            if (vy >= 0) begin
                vx = vx + sy; vy = vy - sx; ang += atan_units(i);
            end else begin
                vx = vx - sy; vy = vy + sx; ang -= atan_units(i);
            end
        end
        return ang;
    endfunction

    function automatic longint to_degrees(longint ang, longint lim);
        longint a;
        a = shr_floor(ang + 256, 9);
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_angles euler_of(longint x, longint y, longint z, longint w);
        longint one, rn, rd, yn, yd, s, c;
        t_angles a;
        one = longint'(1) << 28;
        rn = 2 * (w * x + y * z);
        rd = one - 2 * (x * x + y * y);
        yn = 2 * (w * z + x * y);
        yd = one - 2 * (y * y + z * z);
        s = 2 * (w * y - z * x);
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = floor_sqrt((longint'(1) << 56) - s * s);
        a.roll  = ROLL_W'(to_degrees(vector_angle(rn, rd), ROLL_LIM));
        a.pitch = PITCH_W'(to_degrees(vector_angle(s, c), PITCH_LIM));
        a.yaw   = ROLL_W'(to_degrees(vector_angle(yn, yd), ROLL_LIM));
        return a;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Send one quaternion as a transaction, after a random gap (0 = back to back)
    task automatic send_quat(logic signed [15:0] x, y, z, w);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        qx <= x; qy <= y; qz <= z; qw <= w;
        angles_due = {angles_due, euler_of(x, y, z, w)};
        do @(posedge clk); while (in_stall);
    endtask

    // Receiver: random wait per result, or a long hold-off on request
    always @(posedge clk) begin
        int wait_draw;
        cycles <= cycles + 1;
        if (hold_req && !hold_seen) begin
            hold_seen   <= 1'b1;
            hold_cycles <= HOLD_LEN;
            out_stall   <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end else if (out_valid && !out_stall) begin
            wait_draw = $urandom_range(0, 3);
            rx_wait   <= wait_draw;
            out_stall <= (wait_draw != 0);
        end else if (rx_wait > 0) begin
            rx_wait   <= rx_wait - 1;
            out_stall <= (rx_wait > 1);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk) begin
        t_angles want;
        if (rst_n && out_valid && !out_stall) begin
            if (angles_due.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                errors++;
            end else begin
                want = angles_due.pop_front();
                if (roll !== want.roll) report("roll", roll, want.roll);
                if (pitch !== want.pitch) report("pitch", pitch, want.pitch);
                if (yaw !== want.yaw) report("yaw", yaw, want.yaw);
            end
        end
    end

    // Timeout
    always @(posedge clk) begin
        if (cycles > MAX_CYC) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_identity_and_axes();
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
        send_quat(16'sd0, 16'sd0, 16'sd11585, -16'sd11585);
    endtask

    task automatic test_special_cases();
        // zero quaternion, then x^2 = 0.5 so roll sees a zero vector
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd0);
        // pitch argument beyond unity, both signs
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd16384);
        send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd16384);
        // components beyond one and at the field extremes
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        // angles near +-180
        send_quat(16'sd16384, 16'sd0, 16'sd0, -16'sd1);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd1);
        send_quat(16'sd0, 16'sd0, 16'sd16384, -16'sd1);
    endtask

    task automatic test_random_quats(int n);
        logic signed [15:0] c[4];
        real r[4], norm;
        for (int k = 0; k < n; k++) begin
            if (k % 4 == 3) begin
                foreach (c[j]) c[j] = 16'($urandom);
            end else begin
                // roughly unit quaternion with random direction
                foreach (r[j]) r[j] = real'(int'($urandom_range(0, 65534)) - 32767);
                norm = $sqrt(r[0]*r[0] + r[1]*r[1] + r[2]*r[2] + r[3]*r[3]) + 1.0;
                foreach (c[j]) c[j] = 16'(int'(r[j] * 16384.0 / norm)
                                          + int'($urandom_range(0, 4)) - 2);
            end
            send_quat(c[0], c[1], c[2], c[3]);
        end
    endtask

    // Receiver holds off while the sender keeps the input busy
    task automatic test_backpressure();
        hold_req = 1'b1;
        test_random_quats(80);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_identity_and_axes();
        test_special_cases();
        test_random_quats(250);
        test_backpressure();
        test_random_quats(170);
        in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
